[hw/rtl/voxel_root_slot_insert_core_assert.svh]
// Assertion macros for the voxel root slot store RTL.
`ifndef VOXEL_ROOT_SLOT_INSERT_CORE_ASSERT_SVH
`define VOXEL_ROOT_SLOT_INSERT_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define VRSI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define VRSI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vrsi_pkg.sv]
// Types and constants of the voxel root slot store.
`timescale 1ns / 1ps
`default_nettype none

package vrsi_pkg;

    localparam int VOXEL_W    = 12;
    localparam int VOXEL_SPAN = 4096;
    localparam int SLOT_IDX_W = 4;

    localparam logic [31:0] ERROR_LIMIT_RST  = 32'd1048;
    localparam logic [31:0] MATCH_WINDOW_RST = 32'd1048;

    // Register index as decoded from paddr[2]
    localparam logic REG_ERROR_LIMIT  = 1'b0;
    localparam logic REG_MATCH_WINDOW = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic [31:0] root_time;
        logic [31:0] root_error;
    } slot_entry_t;

    typedef struct packed {
        logic                  accept;
        logic                  write;
        logic [SLOT_IDX_W-1:0] slot;
    } pick_t;

endpackage

`default_nettype wire

[hw/rtl/vrsi_slot_pick.sv]
// Slot decision for one candidate against one voxel's slot row.
`timescale 1ns / 1ps
`default_nettype none

module vrsi_slot_pick
    import vrsi_pkg::*;
#(
    parameter int SLOTS_PER_VOXEL = 4
) (
    input  wire logic                              cand_live,
    input  wire logic [31:0]                       cand_time,
    input  wire logic [31:0]                       cand_error,
    input  wire logic [31:0]                       error_limit,
    input  wire logic [31:0]                       match_window,
    input  wire logic [SLOTS_PER_VOXEL-1:0]        row_full,
    input  wire slot_entry_t [SLOTS_PER_VOXEL-1:0] row_data,
    output pick_t                                  pick
);

    localparam int IW    = (SLOTS_PER_VOXEL > 1) ? $clog2(SLOTS_PER_VOXEL) : 1;
    localparam int LVL   = (SLOTS_PER_VOXEL > 1) ? $clog2(SLOTS_PER_VOXEL) : 0;
    localparam int SP    = 1 << LVL;
    localparam int NODES = 2 * SP - 1;

    logic [SLOTS_PER_VOXEL-1:0] hit;
    logic [SLOTS_PER_VOXEL-1:0] better;
    logic                       match_found;
    logic [SLOT_IDX_W-1:0]      match_idx;
    logic                       empty_found;
    logic [SLOT_IDX_W-1:0]      empty_idx;
    logic [31:0]                tree_err [NODES];
    logic [SLOT_IDX_W-1:0]      tree_idx [NODES];
    logic                       cand_ok;

    assign cand_ok = cand_live && !(cand_error > error_limit);

    // Per-slot distance test and error improvement, all slots in parallel
    always_comb
    begin
        logic signed [32:0] ta;
        logic signed [32:0] tb;
        logic [32:0]        gap_abs;
        hit    = '0;
        better = '0;
        ta     = {cand_time[31], cand_time};
        for (int i = 0; i < SLOTS_PER_VOXEL; i++)
        begin
            tb = {row_data[i].root_time[31], row_data[i].root_time};
            if (ta >= tb)
            begin
                gap_abs = 33'(ta - tb);
            end
            else
            begin
                gap_abs = 33'(tb - ta);
            end
            hit[i]    = row_full[i] && (gap_abs < {1'b0, match_window});
            better[i] = cand_error < row_data[i].root_error;
        end
    end

    // First matching slot and first empty slot
    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int i = SLOTS_PER_VOXEL - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                match_found = 1'b1;
                match_idx   = SLOT_IDX_W'(i);
            end
            if (!row_full[i])
            begin
                empty_found = 1'b1;
                empty_idx   = SLOT_IDX_W'(i);
            end
        end
    end

    // Largest error by compare tree; the left node wins ties, so the first slot is kept
    always_comb
    begin
        for (int i = 0; i < SP; i++)
        begin
            if (i < SLOTS_PER_VOXEL)
            begin
                tree_err[SP-1+i] = row_data[i].root_error;
            end
            else
            begin
                tree_err[SP-1+i] = '0;
            end
            tree_idx[SP-1+i] = SLOT_IDX_W'(i);
        end
        for (int n = SP - 2; n >= 0; n--)
        begin
            if (tree_err[2*n+2] > tree_err[2*n+1])
            begin
                tree_err[n] = tree_err[2*n+2];
                tree_idx[n] = tree_idx[2*n+2];
            end
            else
            begin
                tree_err[n] = tree_err[2*n+1];
                tree_idx[n] = tree_idx[2*n+1];
            end
        end
    end

    always_comb
    begin
        pick = '0;
        if (cand_ok)
        begin
            if (match_found)
            begin
                pick.accept = 1'b1;
                pick.write  = better[match_idx[IW-1:0]];
                pick.slot   = match_idx;
            end
            else if (empty_found)
            begin
                pick.accept = 1'b1;
                pick.write  = 1'b1;
                pick.slot   = empty_idx;
            end
            else if (cand_error < tree_err[0])
            begin
                pick.accept = 1'b1;
                pick.write  = 1'b1;
                pick.slot   = tree_idx[0];
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/voxel_root_slot_insert_core.sv]
// Top level of the per-voxel root slot store with candidate insertion.
// Usage:
//   Configuration: APB-style port, error_limit at byte address 0 and match_window at 4;
//   pready is always high and reads return the register value. Write only while idle.
//   Input: one candidate (voxel, root_time, root_error, candidate_valid) per valid/ready
//   transaction. Output: one result (accepted, slot_sel, slot_changed) per candidate.
//   Timing: the slot row of the voxel is read at the accepting edge; in the decision state
//   it is decided on and written back at the edge on which the result is also registered
//   and out_valid goes high. A new candidate is not taken until the previous one has
//   been written back; this comes from the read-modify-write of the row memory, which
//   also keeps back-to-back candidates on the same voxel in order.
//   Stall: a result waits in the output register; the next candidate is still taken
//   and its row read, then it holds in the decision cycle until the result is taken.
//   Reset: all slots are marked empty by a sweep of one row per cycle over
//   min(VOXEL_COUNT, 4096) rows; in_ready stays low during the sweep, configuration writes
//   are taken. Voxel numbers not below VOXEL_COUNT are rejected.
`timescale 1ns / 1ps
`default_nettype none

`include "voxel_root_slot_insert_core_assert.svh"

module voxel_root_slot_insert_core
    import vrsi_pkg::*;
#(
    parameter int VOXEL_COUNT     = 4096,
    parameter int SLOTS_PER_VOXEL = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VOXEL_W-1:0] voxel,
    input  wire logic signed [31:0] root_time,
    input  wire logic [31:0]        root_error,
    input  wire logic               candidate_valid,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    accepted,
    output logic [1:0]              slot_sel,
    output logic                    slot_changed
);

    localparam int ROWS = (VOXEL_COUNT > VOXEL_SPAN) ? VOXEL_SPAN : VOXEL_COUNT;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IW   = (SLOTS_PER_VOXEL > 1) ? $clog2(SLOTS_PER_VOXEL) : 1;
    localparam logic [AW-1:0]      CLR_LAST  = AW'(ROWS - 1);
    localparam logic [VOXEL_W:0]   ROW_LIMIT = ROWS[VOXEL_W:0];

    state_t                            state_reg;
    state_t                            state_next;
    logic [AW-1:0]                     clr_cnt_reg;
    logic [31:0]                       error_limit_reg;
    logic [31:0]                       match_window_reg;
    logic                              out_valid_reg;
    logic                              accepted_reg;
    logic [1:0]                        slot_sel_reg;
    logic                              slot_changed_reg;
    logic [VOXEL_W-1:0]                voxel_reg;
    logic [31:0]                       root_time_reg;
    logic [31:0]                       root_error_reg;
    logic                              cand_valid_reg;
    logic [SLOTS_PER_VOXEL-1:0]        full_rd_reg;
    slot_entry_t [SLOTS_PER_VOXEL-1:0] data_rd_reg;

    logic [SLOTS_PER_VOXEL-1:0]        full_mem [ROWS];
    slot_entry_t [SLOTS_PER_VOXEL-1:0] data_mem [ROWS];

    logic                              rd_en;
    logic                              clearing;
    logic                              eval_go;
    logic                              data_we;
    logic                              full_we;
    logic [AW-1:0]                     full_wr_addr;
    logic [SLOTS_PER_VOXEL-1:0]        full_wr_row;
    slot_entry_t [SLOTS_PER_VOXEL-1:0] data_wr_row;
    logic                              in_range;
    pick_t                             pick;

    // Configuration registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_limit_reg  <= ERROR_LIMIT_RST;
            match_window_reg <= MATCH_WINDOW_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_ERROR_LIMIT:  error_limit_reg  <= pwdata;
                REG_MATCH_WINDOW: match_window_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ERROR_LIMIT:  prdata = error_limit_reg;
            REG_MATCH_WINDOW: prdata = match_window_reg;
            default:          prdata = '0;
        endcase
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        in_ready = 1'b0;
        clearing = 1'b0;
        eval_go  = 1'b0;
        case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_IDLE:  in_ready = 1'b1;
            ST_EVAL:  eval_go  = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Hold the candidate for the decision cycle
    assign rd_en = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            voxel_reg      <= voxel;
            root_time_reg  <= root_time;
            root_error_reg <= root_error;
            cand_valid_reg <= candidate_valid;
        end
    end

    // Row memories: read at accept, write back when the result retires
    always_ff @(posedge clk)
    begin
        if (full_we)
        begin
            full_mem[full_wr_addr] <= full_wr_row;
        end
        if (rd_en)
        begin
            full_rd_reg <= full_mem[voxel[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[voxel_reg[AW-1:0]] <= data_wr_row;
        end
        if (rd_en)
        begin
            data_rd_reg <= data_mem[voxel[AW-1:0]];
        end
    end

    assign in_range = {1'b0, voxel_reg} < ROW_LIMIT;

    vrsi_slot_pick #(
        .SLOTS_PER_VOXEL (SLOTS_PER_VOXEL)
    ) u_pick (
        .cand_live    (cand_valid_reg && in_range),
        .cand_time    (root_time_reg),
        .cand_error   (root_error_reg),
        .error_limit  (error_limit_reg),
        .match_window (match_window_reg),
        .row_full     (full_rd_reg),
        .row_data     (data_rd_reg),
        .pick         (pick)
    );

    assign data_we = eval_go && pick.write;
    assign full_we = clearing || data_we;

    always_comb
    begin
        full_wr_addr = voxel_reg[AW-1:0];
        full_wr_row  = full_rd_reg;
        data_wr_row  = data_rd_reg;
        full_wr_row[pick.slot[IW-1:0]] = 1'b1;
        data_wr_row[pick.slot[IW-1:0]] = '{root_time: root_time_reg,
                                           root_error: root_error_reg};
        if (clearing)
        begin
            full_wr_addr = clr_cnt_reg;
            full_wr_row  = '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eval_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_go)
        begin
            accepted_reg     <= pick.accept;
            slot_sel_reg     <= pick.slot[1:0];
            slot_changed_reg <= pick.write;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign slot_sel     = slot_sel_reg;
    assign slot_changed = slot_changed_reg;

    `VRSI_ASSERT_IMP(a_no_take_in_clear, state_reg == ST_CLEAR, !in_ready,
        "candidate taken during clearing sweep")
    `VRSI_ASSERT_NXT(a_take_to_eval, in_valid && in_ready, state_reg == ST_EVAL,
        "accepted candidate did not enter the decision cycle")
    `VRSI_ASSERT_IMP(a_write_on_retire, data_we, eval_go && !clearing,
        "row written outside a retiring decision")
    `VRSI_ASSERT_NXT(a_result_after_eval, eval_go, out_valid,
        "decision retired without a result")
    `VRSI_ASSERT_IMP(a_change_needs_accept, out_valid && slot_changed, accepted,
        "slot changed on a rejected candidate")

endmodule

`default_nettype wire
